@@ rtl/tpps_pkg.sv @@
package tpps_pkg;

    localparam int unsigned FreqWidth    = 32;
    localparam int unsigned RateWidth    = 32;
    localparam int unsigned DivWidth     = 16;
    localparam int unsigned LimitWidth   = 17;
    localparam int unsigned CompareWidth = 16;
    localparam int unsigned CfgIdxWidth  = 2;
    localparam int unsigned CfgDataWidth = 32;

    // divisor holds an 18-bit factor times a 32-bit frequency
    localparam int unsigned FactorWidth  = LimitWidth + 1;
    localparam int unsigned DenWidth     = FactorWidth + FreqWidth;
    localparam int unsigned StepWidth    = 5;

    localparam logic [RateWidth-1:0]  ClockRateReset      = 32'd80000000;
    localparam logic [DivWidth-1:0]   ClockDividerReset   = 16'd0;
    localparam logic [LimitWidth-1:0] PrescalerLimitReset = 17'd65536;
    localparam logic [LimitWidth-1:0] PeriodLimitReset    = 17'd65536;

    localparam logic [CfgIdxWidth-1:0] RegClockRate      = 2'd0;
    localparam logic [CfgIdxWidth-1:0] RegClockDivider   = 2'd1;
    localparam logic [CfgIdxWidth-1:0] RegPrescalerLimit = 2'd2;
    localparam logic [CfgIdxWidth-1:0] RegPeriodLimit    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_BASE,
        S_FIRST,
        S_DIV_FIRST,
        S_DECIDE,
        S_DIV_PER,
        S_TAKE,
        S_PUB
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SET_ZERO,
        CMD_SET_BASE,
        CMD_SET_FIRST,
        CMD_SET_PER,
        CMD_SET_CLAMP,
        CMD_STEP,
        CMD_TAKE_PER,
        CMD_PUBLISH
    } t_cmd;

    typedef struct packed {
        logic freq_zero;
        logic fits;
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

@@ rtl/tpps_in_if.sv @@
interface tpps_in_if;
    logic                             valid;
    logic                             ready;
    logic [tpps_pkg::FreqWidth-1:0]   frequency;

    modport source (output valid, output frequency, input ready);
    modport sink   (input valid, input frequency, output ready);
endinterface

@@ rtl/tpps_out_if.sv @@
interface tpps_out_if;
    logic                                valid;
    logic                                ready;
    logic                                valid_res;
    logic [tpps_pkg::LimitWidth-1:0]     prescale;
    logic [tpps_pkg::LimitWidth-1:0]     reload;
    logic [tpps_pkg::CompareWidth-1:0]   compare;

    modport source (output valid, output valid_res, output prescale, output reload,
                    output compare, input ready);
    modport sink   (input valid, input valid_res, input prescale, input reload,
                    input compare, output ready);
endinterface

@@ rtl/tpps_cfg_if.sv @@
interface tpps_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [tpps_pkg::CfgIdxWidth-1:0]    index;
    logic [tpps_pkg::CfgDataWidth-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/tpps_ctrl.sv @@
module tpps_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tpps_pkg::t_dp_status i_status,
    output tpps_pkg::t_cmd       o_cmd
);

    tpps_pkg::t_state r_state;
    tpps_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tpps_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = tpps_pkg::S_CHECK;
                end
            end
            tpps_pkg::S_CHECK: begin
                n_state = i_status.freq_zero ? tpps_pkg::S_PUB : tpps_pkg::S_DIV_BASE;
            end
            tpps_pkg::S_DIV_BASE: begin
                if (i_status.div_last) begin
                    n_state = tpps_pkg::S_FIRST;
                end
            end
            tpps_pkg::S_FIRST: begin
                n_state = tpps_pkg::S_DIV_FIRST;
            end
            tpps_pkg::S_DIV_FIRST: begin
                if (i_status.div_last) begin
                    n_state = tpps_pkg::S_DECIDE;
                end
            end
            tpps_pkg::S_DECIDE: begin
                n_state = i_status.fits ? tpps_pkg::S_DIV_PER : tpps_pkg::S_PUB;
            end
            tpps_pkg::S_DIV_PER: begin
                if (i_status.div_last) begin
                    n_state = tpps_pkg::S_TAKE;
                end
            end
            tpps_pkg::S_TAKE: begin
                n_state = tpps_pkg::S_PUB;
            end
            tpps_pkg::S_PUB: begin
                if (i_status.out_free) begin
                    n_state = tpps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tpps_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = tpps_pkg::CMD_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            tpps_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd = tpps_pkg::CMD_LOAD;
                end
            end
            tpps_pkg::S_CHECK: begin
                o_cmd = i_status.freq_zero ? tpps_pkg::CMD_SET_ZERO : tpps_pkg::CMD_SET_BASE;
            end
            tpps_pkg::S_DIV_BASE,
            tpps_pkg::S_DIV_FIRST,
            tpps_pkg::S_DIV_PER: begin
                o_cmd = tpps_pkg::CMD_STEP;
            end
            tpps_pkg::S_FIRST: begin
                o_cmd = tpps_pkg::CMD_SET_FIRST;
            end
            tpps_pkg::S_DECIDE: begin
                o_cmd = i_status.fits ? tpps_pkg::CMD_SET_PER : tpps_pkg::CMD_SET_CLAMP;
            end
            tpps_pkg::S_TAKE: begin
                o_cmd = tpps_pkg::CMD_TAKE_PER;
            end
            tpps_pkg::S_PUB: begin
                if (i_status.out_free) begin
                    o_cmd = tpps_pkg::CMD_PUBLISH;
                end
            end
            default: begin
                o_cmd = tpps_pkg::CMD_NONE;
            end
        endcase
    end

endmodule

@@ rtl/tpps_dp.sv @@
module tpps_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tpps_pkg::t_cmd                       i_cmd,
    output tpps_pkg::t_dp_status                 o_status,
    input  logic [tpps_pkg::FreqWidth-1:0]       i_frequency,
    input  logic                                 i_cfg_valid,
    input  logic [tpps_pkg::CfgIdxWidth-1:0]     i_cfg_index,
    input  logic [tpps_pkg::CfgDataWidth-1:0]    i_cfg_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_valid_res,
    output logic [tpps_pkg::LimitWidth-1:0]      o_prescale,
    output logic [tpps_pkg::LimitWidth-1:0]      o_reload,
    output logic [tpps_pkg::CompareWidth-1:0]    o_compare
);

    localparam int unsigned QW = tpps_pkg::FreqWidth;
    localparam int unsigned DW = tpps_pkg::DenWidth;
    localparam int unsigned LW = tpps_pkg::LimitWidth;
    localparam int unsigned FW = tpps_pkg::FactorWidth;
    localparam int unsigned SW = tpps_pkg::StepWidth;

    // configuration
    logic [tpps_pkg::RateWidth-1:0] r_clock_rate;
    logic [tpps_pkg::DivWidth-1:0]  r_clock_divider;
    logic [LW-1:0]                  r_pre_lim;
    logic [LW-1:0]                  r_per_lim;

    // request and working registers
    logic [QW-1:0] r_freq;
    logic [QW-1:0] r_base;
    logic [QW-1:0] r_num;   // dividend in, quotient out
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [SW-1:0] r_cnt;
    logic          r_vres;
    logic [LW-1:0] r_pre;
    logic [LW-1:0] r_per;

    // result register
    logic          r_out_valid;
    logic          r_out_vres;
    logic [LW-1:0] r_out_pre;
    logic [LW-1:0] r_out_per;

    logic [DW:0]   w_shift;
    logic [DW+1:0] w_diff;
    logic          n_bit;
    logic [DW-1:0] n_rem;
    logic [FW-1:0] w_factor;
    logic [DW-1:0] w_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_rate    <= tpps_pkg::ClockRateReset;
            r_clock_divider <= tpps_pkg::ClockDividerReset;
            r_pre_lim       <= tpps_pkg::PrescalerLimitReset;
            r_per_lim       <= tpps_pkg::PeriodLimitReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tpps_pkg::RegClockRate:      r_clock_rate    <= i_cfg_data;
                tpps_pkg::RegClockDivider:   r_clock_divider <= i_cfg_data[tpps_pkg::DivWidth-1:0];
                tpps_pkg::RegPrescalerLimit: r_pre_lim       <= i_cfg_data[LW-1:0];
                tpps_pkg::RegPeriodLimit:    r_per_lim       <= i_cfg_data[LW-1:0];
                default: begin
                end
            endcase
        end
    end

    // one restoring step: shift in the next dividend bit, subtract when it fits
    always_comb begin
        w_shift = {r_rem, r_num[QW-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, r_den};
        n_bit   = ~w_diff[DW+1];
        n_rem   = n_bit ? w_diff[DW-1:0] : w_shift[DW-1:0];
    end

    // factor times frequency, shared by both searches
    always_comb begin
        if (i_cmd == tpps_pkg::CMD_SET_FIRST) begin
            w_factor = {1'b0, r_per_lim} + FW'(1);
        end else begin
            w_factor = {1'b0, r_num[LW-1:0]} + FW'(1);
        end
        w_prod = DW'(w_factor) * DW'(r_freq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case (i_cmd)
                tpps_pkg::CMD_SET_BASE,
                tpps_pkg::CMD_SET_FIRST,
                tpps_pkg::CMD_SET_PER: r_cnt <= '0;
                tpps_pkg::CMD_STEP:    r_cnt <= r_cnt + SW'(1);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            tpps_pkg::CMD_LOAD: begin
                r_freq <= i_frequency;
            end
            tpps_pkg::CMD_SET_ZERO: begin
                r_vres <= 1'b0;
                r_pre  <= '0;
                r_per  <= '0;
            end
            tpps_pkg::CMD_SET_BASE: begin
                r_num <= r_clock_rate;
                r_rem <= '0;
                r_den <= DW'(r_clock_divider) + DW'(1);
            end
            tpps_pkg::CMD_SET_FIRST: begin
                r_base <= r_num;
                r_rem  <= '0;
                r_den  <= w_prod;
            end
            tpps_pkg::CMD_SET_PER: begin
                r_vres <= 1'b1;
                r_pre  <= r_num[LW-1:0];
                r_num  <= r_base;
                r_rem  <= '0;
                r_den  <= w_prod;
            end
            tpps_pkg::CMD_SET_CLAMP: begin
                r_vres <= 1'b1;
                r_pre  <= r_pre_lim;
                r_per  <= r_per_lim;
            end
            tpps_pkg::CMD_STEP: begin
                r_num <= {r_num[QW-2:0], n_bit};
                r_rem <= n_rem;
            end
            tpps_pkg::CMD_TAKE_PER: begin
                r_per <= r_num[LW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd == tpps_pkg::CMD_PUBLISH) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == tpps_pkg::CMD_PUBLISH) begin
            r_out_vres <= r_vres;
            r_out_pre  <= r_pre;
            r_out_per  <= r_per;
        end
    end

    assign o_status.freq_zero = (r_freq == '0);
    assign o_status.fits      = (r_num[QW-1:LW] == '0) && (r_num[LW-1:0] <= r_pre_lim);
    assign o_status.div_last  = (r_cnt == SW'(QW - 1));
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_valid_res = r_out_vres;
    assign o_prescale  = r_out_pre;
    assign o_reload    = r_out_per;
    assign o_compare   = r_out_per[LW-1:1];

endmodule

@@ rtl/timer_prescaler_period_search.sv @@
// Timer prescaler and period search. For each requested frequency the block
// returns the smallest prescaler whose period fits the period limit, that
// period, and half of it as a compare value; a zero frequency returns an
// invalid, all-zero result; a prescaler above the prescaler limit returns
// both limits as a valid result. Up to three 32-bit divisions, for the
// base clock, the prescaler and the period, run one after another through a
// single restoring divider that produces one quotient bit per cycle. One
// request is in work at a time; the result register lets the next request
// be accepted while a finished result waits on the output. Configuration
// writes are always accepted and must only occur while no request is in work.
module timer_prescaler_period_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tpps_in_if.sink     i_in,
    tpps_out_if.source  o_out,
    tpps_cfg_if.sink    i_cfg
);

    tpps_pkg::t_cmd       w_cmd;
    tpps_pkg::t_dp_status w_status;
    logic                 w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    tpps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tpps_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_frequency (i_in.frequency),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_valid_res (o_out.valid_res),
        .o_prescale  (o_out.prescale),
        .o_reload    (o_out.reload),
        .o_compare   (o_out.compare)
    );

endmodule
